@@ design/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define JDRC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("jdrc assertion failed");

// clocked assertion that also covers the reset cycles
`define JDRC_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("jdrc reset assertion failed");

`endif

@@ design/jdrc_pkg.sv @@
// shared constants, types and codes of the joystick drive ramp controller
package jdrc_pkg;

    localparam int STICK_W    = 16;
    localparam int THR_W      = 15;
    localparam int POW_W      = 7;
    localparam int GAIN_W     = 4;
    localparam int SPAN_W     = 8;
    localparam int PCT_W      = 6;
    localparam int STROKE_W   = 10;
    localparam int LVL_W      = 8;
    localparam int OUT_POW_W  = 9;
    localparam int MOVE_W     = 11;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam int DIFF_W     = LVL_W + 2;
    localparam int PROD_W     = 12;
    localparam int STEP_W     = 9;
    localparam int SPROD_W    = 15;
    localparam int FACT_W     = 8;

    localparam int RECIP_W       = 13;
    localparam logic [RECIP_W-1:0] RECIP10  = 13'd6554;
    localparam int RECIP10_SH    = 16;
    localparam logic [RECIP_W-1:0] RECIP100 = 13'd5243;
    localparam int RECIP100_SH   = 19;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    localparam logic [MODE_W-1:0] MODE_STOP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FWD  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BACK = 2'd2;

    localparam logic KIND_JOY  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_STICK_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_POWER       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_TENTHS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_SPAN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST_PERCENT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFT_STROKE     = 3'd5;

    localparam logic [THR_W-1:0]    RST_STICK_THRESHOLD = 15'd16384;
    localparam logic [POW_W-1:0]    RST_TOP_POWER       = 7'd90;
    localparam logic [GAIN_W-1:0]   RST_GAIN_TENTHS     = 4'd8;
    localparam logic [SPAN_W-1:0]   RST_UPDATE_SPAN     = 8'd2;
    localparam logic [PCT_W-1:0]    RST_BOOST_PERCENT   = 6'd10;
    localparam logic [STROKE_W-1:0] RST_LIFT_STROKE     = 10'd150;

    typedef struct packed {
        logic [THR_W-1:0]    stick_threshold;
        logic [POW_W-1:0]    top_power;
        logic [GAIN_W-1:0]   gain_tenths;
        logic [SPAN_W-1:0]   update_span;
        logic [PCT_W-1:0]    boost_percent;
        logic [STROKE_W-1:0] lift_stroke;
    } t_cfg;

    typedef struct packed {
        logic              kind;
        logic [MODE_W-1:0] drive_mode;
        logic [MODE_W-1:0] lift_mode;
        logic              right_button;
        logic              left_button;
    } t_item;

    typedef struct packed {
        logic                     valid;
        logic signed [LVL_W-1:0]  lvl_l;
        logic signed [LVL_W-1:0]  lvl_r;
        logic                     sc_l;
        logic                     sc_r;
        logic                     lift_valid;
        logic signed [MOVE_W-1:0] lift_move;
    } t_ramp;

endpackage

@@ design/jdrc_in_if.sv @@
// input channel: joystick events and control ticks
interface jdrc_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   kind;
    logic signed [jdrc_pkg::STICK_W-1:0]    stick_forward;
    logic signed [jdrc_pkg::STICK_W-1:0]    stick_lift;
    logic                                   right_button;
    logic                                   left_button;

    modport source (output valid, kind, stick_forward, stick_lift, right_button,
                    left_button, input ready);
    modport sink   (input valid, kind, stick_forward, stick_lift, right_button,
                    left_button, output ready);
endinterface

@@ design/jdrc_out_if.sv @@
// output channel: drive powers and lift command
interface jdrc_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [jdrc_pkg::OUT_POW_W-1:0]  left_power;
    logic signed [jdrc_pkg::OUT_POW_W-1:0]  right_power;
    logic                                   lift_valid;
    logic signed [jdrc_pkg::MOVE_W-1:0]     lift_move;

    modport source (output valid, left_power, right_power, lift_valid, lift_move,
                    input ready);
    modport sink   (input valid, left_power, right_power, lift_valid, lift_move,
                    output ready);
endinterface

@@ design/jdrc_queue.sv @@
// two-entry queue of classified items between front and back
module jdrc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  jdrc_pkg::t_item i_item,
    input  logic            i_pop,
    output jdrc_pkg::t_item o_head,
    output logic            o_full,
    output logic            o_empty
);

    jdrc_pkg::t_item                 r_mem [jdrc_pkg::Q_DEPTH];
    logic [jdrc_pkg::Q_PTR_W-1:0]    r_wr_ptr;
    logic [jdrc_pkg::Q_PTR_W-1:0]    r_rd_ptr;
    logic [jdrc_pkg::Q_CNT_W-1:0]    r_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == jdrc_pkg::Q_CNT_W'(jdrc_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ design/jdrc_front.sv @@
// front end: takes input transfers and classifies the stick axes
module jdrc_front (
    jdrc_in_if.sink                      i_in,
    input  logic [jdrc_pkg::THR_W-1:0]   i_threshold,
    input  logic                         i_q_full,
    output logic                         o_push,
    output jdrc_pkg::t_item              o_item
);

    function automatic logic [jdrc_pkg::MODE_W-1:0] classify(
        input logic signed [jdrc_pkg::STICK_W-1:0] s,
        input logic [jdrc_pkg::THR_W-1:0]          t
    );
        logic signed [jdrc_pkg::STICK_W:0] sx;
        logic signed [jdrc_pkg::STICK_W:0] tx;
        sx = {s[jdrc_pkg::STICK_W-1], s};
        tx = {2'b00, t};
        if (sx >= tx) begin
            return jdrc_pkg::MODE_FWD;
        end else if (sx <= -tx) begin
            return jdrc_pkg::MODE_BACK;
        end
        return jdrc_pkg::MODE_STOP;
    endfunction

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    always_comb begin
        o_item.kind         = i_in.kind;
        o_item.drive_mode   = classify(i_in.stick_forward, i_threshold);
        o_item.lift_mode    = classify(i_in.stick_lift, i_threshold);
        o_item.right_button = i_in.right_button;
        o_item.left_button  = i_in.left_button;
    end

endmodule

@@ design/jdrc_back.sv @@
// back end: mode state, span counter, power ramp and lift command
module jdrc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  jdrc_pkg::t_cfg   i_cfg,
    input  logic             i_q_empty,
    input  jdrc_pkg::t_item  i_q_head,
    output logic             o_q_pop,
    output jdrc_pkg::t_ramp  o_ramp,
    input  logic             i_ramp_ready
);

    localparam int LW = jdrc_pkg::LVL_W;
    localparam int DW = jdrc_pkg::DIFF_W;
    localparam int PW = jdrc_pkg::PROD_W;
    localparam int SW = jdrc_pkg::STEP_W;
    localparam int RW = jdrc_pkg::RECIP_W;

    logic                          r_busy;
    logic                          r_do_step;
    logic                          r_neg_l, r_neg_r;
    logic                          r_nz_l, r_nz_r;
    logic [PW-1:0]                 r_prod_l, r_prod_r;
    logic [jdrc_pkg::MODE_W-1:0]   r_drive_mode;
    logic [jdrc_pkg::SPAN_W-1:0]   r_span;
    logic signed [LW-1:0]          r_lvl_l, r_lvl_r;
    logic                          r_held_l, r_held_r;
    logic [jdrc_pkg::MODE_W-1:0]   r_lift_mode;
    logic [jdrc_pkg::MODE_W-1:0]   r_lift_sent;

    logic                          tick_pop;
    logic                          joy_pop;
    logic                          done;
    logic signed [LW-1:0]          target;
    logic signed [DW-1:0]          diff_l, diff_r;
    logic signed [LW-1:0]          nl_l, nl_r;
    logic                          lift_chg;

    function automatic logic [PW-1:0] step_prod(
        input logic signed [DW-1:0]          d,
        input logic [jdrc_pkg::GAIN_W-1:0]   g
    );
        logic [DW-1:0] m;
        m = d[DW-1] ? (~d + 1'b1) : d;
        return {{(PW-LW){1'b0}}, m[LW-1:0]} * {{(PW-jdrc_pkg::GAIN_W){1'b0}}, g};
    endfunction

    function automatic logic signed [LW-1:0] ramp_next(
        input logic signed [LW-1:0] lvl,
        input logic [PW-1:0]        prod,
        input logic                 neg,
        input logic                 nz
    );
        logic [PW+RW-1:0]     wide;
        logic [SW-1:0]        step;
        logic signed [SW+1:0] nl;
        wide = {{RW{1'b0}}, prod} * {{PW{1'b0}}, jdrc_pkg::RECIP10};
        step = wide[jdrc_pkg::RECIP10_SH +: SW];
        if (step == '0 && nz) begin
            step = SW'(1);
        end
        if (neg) begin
            nl = {{(SW+2-LW){lvl[LW-1]}}, lvl} - {2'b00, step};
        end else begin
            nl = {{(SW+2-LW){lvl[LW-1]}}, lvl} + {2'b00, step};
        end
        if (nl > 11'sd127) begin
            return 8'sd127;
        end else if (nl < -11'sd128) begin
            return -8'sd128;
        end
        return nl[LW-1:0];
    endfunction

    assign o_q_pop  = !r_busy && !i_q_empty;
    assign tick_pop = o_q_pop && (i_q_head.kind == jdrc_pkg::KIND_TICK);
    assign joy_pop  = o_q_pop && (i_q_head.kind == jdrc_pkg::KIND_JOY);
    assign done     = r_busy && i_ramp_ready;
    assign lift_chg = (r_lift_mode != r_lift_sent);

    always_comb begin
        case (r_drive_mode)
            jdrc_pkg::MODE_FWD:  target = {1'b0, i_cfg.top_power};
            jdrc_pkg::MODE_BACK: target = -$signed({1'b0, i_cfg.top_power});
            default:             target = '0;
        endcase
        diff_l = {{(DW-LW){target[LW-1]}}, target} - {{(DW-LW){r_lvl_l[LW-1]}}, r_lvl_l};
        diff_r = {{(DW-LW){target[LW-1]}}, target} - {{(DW-LW){r_lvl_r[LW-1]}}, r_lvl_r};
        nl_l   = ramp_next(r_lvl_l, r_prod_l, r_neg_l, r_nz_l);
        nl_r   = ramp_next(r_lvl_r, r_prod_r, r_neg_r, r_nz_r);
    end

    always_comb begin
        o_ramp.valid      = r_busy;
        o_ramp.lvl_l      = r_do_step ? nl_l : r_lvl_l;
        o_ramp.lvl_r      = r_do_step ? nl_r : r_lvl_r;
        o_ramp.sc_l       = r_held_r && !r_held_l;
        o_ramp.sc_r       = r_held_l && !r_held_r;
        o_ramp.lift_valid = 1'b0;
        o_ramp.lift_move  = '0;
        if (lift_chg) begin
            case (r_lift_mode)
                jdrc_pkg::MODE_FWD: begin
                    o_ramp.lift_valid = 1'b1;
                    o_ramp.lift_move  = {1'b0, i_cfg.lift_stroke};
                end
                jdrc_pkg::MODE_BACK: begin
                    o_ramp.lift_valid = 1'b1;
                    o_ramp.lift_move  = -$signed({1'b0, i_cfg.lift_stroke});
                end
                default: begin
                    o_ramp.lift_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_pop) begin
            r_do_step <= (r_span == i_cfg.update_span);
            r_neg_l   <= diff_l[DW-1];
            r_neg_r   <= diff_r[DW-1];
            r_nz_l    <= (diff_l != '0);
            r_nz_r    <= (diff_r != '0);
            r_prod_l  <= step_prod(diff_l, i_cfg.gain_tenths);
            r_prod_r  <= step_prod(diff_r, i_cfg.gain_tenths);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_drive_mode <= jdrc_pkg::MODE_STOP;
            r_span       <= '0;
            r_lvl_l      <= '0;
            r_lvl_r      <= '0;
            r_held_l     <= 1'b0;
            r_held_r     <= 1'b0;
            r_lift_mode  <= jdrc_pkg::MODE_STOP;
            r_lift_sent  <= jdrc_pkg::MODE_STOP;
        end else begin
            if (tick_pop) begin
                r_busy <= 1'b1;
            end
            if (joy_pop) begin
                r_held_r <= i_q_head.right_button;
                r_held_l <= i_q_head.left_button;
                if (i_q_head.drive_mode != r_drive_mode) begin
                    r_drive_mode <= i_q_head.drive_mode;
                    r_span       <= '0;
                end
                if (i_q_head.lift_mode != jdrc_pkg::MODE_STOP) begin
                    r_lift_mode <= i_q_head.lift_mode;
                end
            end
            if (done) begin
                r_busy <= 1'b0;
                if (r_do_step) begin
                    r_lvl_l <= nl_l;
                    r_lvl_r <= nl_r;
                    r_span  <= jdrc_pkg::SPAN_W'(1);
                end else begin
                    r_span  <= r_span + 1'b1;
                end
                if (lift_chg) begin
                    r_lift_sent <= r_lift_mode;
                end
            end
        end
    end

endmodule

@@ design/jdrc_scale.sv @@
// bumper scaling pipeline and output register
module jdrc_scale (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [jdrc_pkg::PCT_W-1:0]  i_pct,
    input  jdrc_pkg::t_ramp             i_ramp,
    output logic                        o_ramp_ready,
    jdrc_out_if.source                  o_out
);

    localparam int LW = jdrc_pkg::LVL_W;
    localparam int QW = jdrc_pkg::OUT_POW_W;
    localparam int PW = jdrc_pkg::SPROD_W;
    localparam int FW = jdrc_pkg::FACT_W;
    localparam int RW = jdrc_pkg::RECIP_W;

    jdrc_pkg::t_ramp                    r_a;
    logic                               r_b_valid;
    logic [PW-1:0]                      r_b_prod_l, r_b_prod_r;
    logic signed [LW-1:0]               r_b_raw_l, r_b_raw_r;
    logic                               r_b_sc_l, r_b_sc_r;
    logic                               r_b_lift_valid;
    logic signed [jdrc_pkg::MOVE_W-1:0] r_b_lift_move;
    logic                               r_o_valid;
    logic signed [QW-1:0]               r_o_left, r_o_right;
    logic                               r_o_lift_valid;
    logic signed [jdrc_pkg::MOVE_W-1:0] r_o_lift_move;

    logic out_free;
    logic b_free;
    logic a_free;

    function automatic logic [PW-1:0] sc_prod(
        input logic signed [LW-1:0]        x,
        input logic [jdrc_pkg::PCT_W-1:0]  pct
    );
        logic [LW-1:0]   m;
        logic [FW-1:0]   f;
        logic [2*LW-1:0] p;
        m = x[LW-1] ? (~x + 1'b1) : x;
        f = x[LW-1] ? (FW'(100) - {{(FW-jdrc_pkg::PCT_W){1'b0}}, pct})
                    : (FW'(100) + {{(FW-jdrc_pkg::PCT_W){1'b0}}, pct});
        p = {{LW{1'b0}}, m} * {{(2*LW-FW){1'b0}}, f};
        return p[PW-1:0];
    endfunction

    function automatic logic signed [QW-1:0] sc_out(
        input logic [PW-1:0]        prod,
        input logic signed [LW-1:0] raw,
        input logic                 sc
    );
        logic [PW+RW-1:0] w;
        logic [QW-1:0]    q;
        w = {{RW{1'b0}}, prod} * {{PW{1'b0}}, jdrc_pkg::RECIP100};
        q = w[jdrc_pkg::RECIP100_SH +: QW];
        if (!sc) begin
            return {raw[LW-1], raw};
        end
        return raw[LW-1] ? (~q + 1'b1) : q;
    endfunction

    assign out_free     = !r_o_valid || o_out.ready;
    assign b_free       = !r_b_valid || out_free;
    assign a_free       = !r_a.valid || b_free;
    assign o_ramp_ready = a_free;

    assign o_out.valid       = r_o_valid;
    assign o_out.left_power  = r_o_left;
    assign o_out.right_power = r_o_right;
    assign o_out.lift_valid  = r_o_lift_valid;
    assign o_out.lift_move   = r_o_lift_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (a_free) begin
                r_a.valid <= i_ramp.valid;
            end
            if (b_free) begin
                r_b_valid <= r_a.valid;
            end
            if (out_free) begin
                r_o_valid <= r_b_valid;
            end
        end
        if (a_free) begin
            r_a.lvl_l      <= i_ramp.lvl_l;
            r_a.lvl_r      <= i_ramp.lvl_r;
            r_a.sc_l       <= i_ramp.sc_l;
            r_a.sc_r       <= i_ramp.sc_r;
            r_a.lift_valid <= i_ramp.lift_valid;
            r_a.lift_move  <= i_ramp.lift_move;
        end
        if (b_free) begin
            r_b_prod_l     <= sc_prod(r_a.lvl_l, i_pct);
            r_b_prod_r     <= sc_prod(r_a.lvl_r, i_pct);
            r_b_raw_l      <= r_a.lvl_l;
            r_b_raw_r      <= r_a.lvl_r;
            r_b_sc_l       <= r_a.sc_l;
            r_b_sc_r       <= r_a.sc_r;
            r_b_lift_valid <= r_a.lift_valid;
            r_b_lift_move  <= r_a.lift_move;
        end
        if (out_free) begin
            r_o_left       <= sc_out(r_b_prod_l, r_b_raw_l, r_b_sc_l);
            r_o_right      <= sc_out(r_b_prod_r, r_b_raw_r, r_b_sc_r);
            r_o_lift_valid <= r_b_lift_valid;
            r_o_lift_move  <= r_b_lift_move;
        end
    end

endmodule

@@ design/joystick_drive_ramp_controller.sv @@
// Joystick drive ramp controller top level. Joystick events and control ticks enter on i_in;
// each tick produces one transfer on o_out with both drive powers and an optional lift
// command, joystick events produce none. Input transfers are classified on arrival and
// held in a two-entry queue, so i_in stays ready while o_out is stalled until the queue
// fills. The back end applies a joystick event when it pops it; for a tick it first registers
// gain times power difference, then scales it by one tenth and, once the span counter has
// reached the update span, updates the power levels. It pops no new item until the scaling
// stage has taken the tick's result. The bumper scaling then runs in a three-register pipeline.
// Configuration writes on i_cfg_we go to a register that the other stages read directly.
module joystick_drive_ramp_controller (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    jdrc_in_if.sink                            i_in,
    jdrc_out_if.source                         o_out,
    input  logic                               i_cfg_we,
    input  logic [jdrc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [jdrc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    jdrc_pkg::t_cfg  r_cfg;
    jdrc_pkg::t_item push_item;
    jdrc_pkg::t_item q_head;
    jdrc_pkg::t_ramp ramp;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;
    logic            ramp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stick_threshold <= jdrc_pkg::RST_STICK_THRESHOLD;
            r_cfg.top_power       <= jdrc_pkg::RST_TOP_POWER;
            r_cfg.gain_tenths     <= jdrc_pkg::RST_GAIN_TENTHS;
            r_cfg.update_span     <= jdrc_pkg::RST_UPDATE_SPAN;
            r_cfg.boost_percent   <= jdrc_pkg::RST_BOOST_PERCENT;
            r_cfg.lift_stroke     <= jdrc_pkg::RST_LIFT_STROKE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                jdrc_pkg::CFG_STICK_THRESHOLD:
                    r_cfg.stick_threshold <= i_cfg_data[jdrc_pkg::THR_W-1:0];
                jdrc_pkg::CFG_TOP_POWER:
                    r_cfg.top_power       <= i_cfg_data[jdrc_pkg::POW_W-1:0];
                jdrc_pkg::CFG_GAIN_TENTHS:
                    r_cfg.gain_tenths     <= i_cfg_data[jdrc_pkg::GAIN_W-1:0];
                jdrc_pkg::CFG_UPDATE_SPAN:
                    r_cfg.update_span     <= i_cfg_data[jdrc_pkg::SPAN_W-1:0];
                jdrc_pkg::CFG_BOOST_PERCENT:
                    r_cfg.boost_percent   <= i_cfg_data[jdrc_pkg::PCT_W-1:0];
                jdrc_pkg::CFG_LIFT_STROKE:
                    r_cfg.lift_stroke     <= i_cfg_data[jdrc_pkg::STROKE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    jdrc_front u_front (
        .i_in        (i_in),
        .i_threshold (r_cfg.stick_threshold),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_item      (push_item)
    );

    jdrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    jdrc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_empty    (q_empty),
        .i_q_head     (q_head),
        .o_q_pop      (pop),
        .o_ramp       (ramp),
        .i_ramp_ready (ramp_ready)
    );

    jdrc_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pct        (r_cfg.boost_percent),
        .i_ramp       (ramp),
        .o_ramp_ready (ramp_ready),
        .o_out        (o_out)
    );

endmodule

@@ design/jdrc_checker.sv @@
// port-level checker for the joystick drive ramp controller, with its bind
`include "assert_macros.svh"

module jdrc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic signed [jdrc_pkg::OUT_POW_W-1:0] i_out_left_power,
    input logic signed [jdrc_pkg::OUT_POW_W-1:0] i_out_right_power,
    input logic                                i_out_lift_valid,
    input logic signed [jdrc_pkg::MOVE_W-1:0]  i_out_lift_move
);

    logic [2*jdrc_pkg::OUT_POW_W+jdrc_pkg::MOVE_W:0] out_payload;

    assign out_payload = {i_out_left_power, i_out_right_power, i_out_lift_valid,
                          i_out_lift_move};

    `JDRC_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid)
    `JDRC_ASSERT(a_out_stable, i_out_valid && !i_out_ready |=> $stable(out_payload))
    `JDRC_ASSERT(a_move_zero, i_out_valid && !i_out_lift_valid |-> i_out_lift_move == '0)
    `JDRC_ASSERT_RST(a_rst_idle, !i_rst_n |=> !i_out_valid && i_in_ready)

endmodule

bind joystick_drive_ramp_controller jdrc_checker u_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_left_power  (o_out.left_power),
    .i_out_right_power (o_out.right_power),
    .i_out_lift_valid  (o_out.lift_valid),
    .i_out_lift_move   (o_out.lift_move)
);

@@ tb/joystick_drive_ramp_controller_test.sv @@
// testbench for the joystick drive ramp controller: directed table, then random phases
`timescale 1ns / 1ps

module joystick_drive_ramp_controller_test;

    localparam int DIRECTED_ROWS = 24;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 125;
    localparam int DRAIN_CYCLES  = 20;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 80;

    typedef struct packed {
        logic signed [jdrc_pkg::OUT_POW_W-1:0] left_power;
        logic signed [jdrc_pkg::OUT_POW_W-1:0] right_power;
        logic                                  lift_valid;
        logic signed [jdrc_pkg::MOVE_W-1:0]    lift_move;
    } t_power_cmd;

    typedef struct {
        logic       kind;
        int         fwd;
        int         lift;
        logic       right_button;
        logic       left_button;
        bit         typed;
        t_power_cmd want;
    } t_joy_item;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [jdrc_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [jdrc_pkg::CFG_DATA_W-1:0] i_cfg_data;

    jdrc_in_if  joy_ch ();
    jdrc_out_if cmd_ch ();

    joystick_drive_ramp_controller i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (joy_ch),
        .o_out      (cmd_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    jdrc_pkg::t_cfg                     cfg;
    logic [jdrc_pkg::MODE_W-1:0]        drive_mode;
    logic [jdrc_pkg::SPAN_W-1:0]        span_cnt;
    logic signed [jdrc_pkg::LVL_W-1:0]  left_lvl;
    logic signed [jdrc_pkg::LVL_W-1:0]  right_lvl;
    logic                               right_held;
    logic                               left_held;
    logic [jdrc_pkg::MODE_W-1:0]        lift_mode;
    logic [jdrc_pkg::MODE_W-1:0]        lift_sent;

    t_power_cmd pending_cmds [$];
    int         mismatch_count = 0;
    int         quiet_cycles = 0;
    int         sender_idle_pct = 0;
    int         receiver_stall_pct = 0;
    int         hold_request = 0;
    int         last_fwd = 0;

    t_joy_item directed_rows [DIRECTED_ROWS] = '{
        '{jdrc_pkg::KIND_TICK, 0, 0, 1'b0, 1'b0, 1'b1, '{9'sd0, 9'sd0, 1'b0, 11'sd0}},
        '{jdrc_pkg::KIND_JOY, 16384, 32767, 1'b0, 1'b0, 1'b0, '0},
        '{jdrc_pkg::KIND_TICK, 0, 0, 1'b0, 1'b0, 1'b1, '{9'sd0, 9'sd0, 1'b1, 11'sd150}},
        '{jdrc_pkg::KIND_TICK, 0, 0, 1'b0, 1'b0, 1'b0, '0},
        '{jdrc_pkg::KIND_TICK, 0, 0, 1'b0, 1'b0, 1'b0, '0},
        '{jdrc_pkg::KIND_JOY, 16383, -32768, 1'b1, 1'b0, 1'b0, '0},
        '{jdrc_pkg::KIND_TICK, 0, 0, 1'b0, 1'b0, 1'b0, '0},
        '{jdrc_pkg::KIND_TICK, 0, 0, 1'b0, 1'b0, 1'b0, '0},
        '{jdrc_pkg::KIND_TICK, 0, 0, 1'b0, 1'b0, 1'b0, '0},
        '{jdrc_pkg::KIND_JOY, -16384, 0, 1'b0, 1'b1, 1'b0, '0},
        '{jdrc_pkg::KIND_TICK, 0, 0, 1'b0, 1'b0, 1'b0, '0},
        '{jdrc_pkg::KIND_TICK, 0, 0, 1'b0, 1'b0, 1'b0, '0},
        '{jdrc_pkg::KIND_TICK, 0, 0, 1'b0, 1'b0, 1'b0, '0},
        '{jdrc_pkg::KIND_JOY, -32768, 16384, 1'b1, 1'b1, 1'b0, '0},
        '{jdrc_pkg::KIND_TICK, 0, 0, 1'b0, 1'b0, 1'b0, '0},
        '{jdrc_pkg::KIND_TICK, 0, 0, 1'b0, 1'b0, 1'b0, '0},
        '{jdrc_pkg::KIND_TICK, 0, 0, 1'b0, 1'b0, 1'b0, '0},
        '{jdrc_pkg::KIND_JOY, -16383, -16384, 1'b0, 1'b0, 1'b0, '0},
        '{jdrc_pkg::KIND_TICK, 0, 0, 1'b0, 1'b0, 1'b0, '0},
        '{jdrc_pkg::KIND_TICK, 0, 0, 1'b0, 1'b0, 1'b0, '0},
        '{jdrc_pkg::KIND_JOY, 32767, -16383, 1'b1, 1'b0, 1'b0, '0},
        '{jdrc_pkg::KIND_TICK, 0, 0, 1'b0, 1'b0, 1'b0, '0},
        '{jdrc_pkg::KIND_TICK, 0, 0, 1'b0, 1'b0, 1'b0, '0},
        '{jdrc_pkg::KIND_TICK, 0, 0, 1'b0, 1'b0, 1'b0, '0}
    };

    function automatic logic [jdrc_pkg::MODE_W-1:0] stick_to_mode(int pos);
        int thr;
        thr = int'(cfg.stick_threshold);
        if (pos >= thr) return jdrc_pkg::MODE_FWD;
        if (pos <= -thr) return jdrc_pkg::MODE_BACK;
        return jdrc_pkg::MODE_STOP;
    endfunction

    function automatic int next_level(int level, int target);
        int diff;
        int mag;
        int step;
        int lvl;
        diff = target - level;
        mag = (diff < 0) ? -diff : diff;
        step = (mag * int'(cfg.gain_tenths)) / 10;
        if (step == 0 && mag != 0) step = 1;
        lvl = (diff < 0) ? level - step : level + step;
        if (lvl > 127) lvl = 127;
        if (lvl < -128) lvl = -128;
        return lvl;
    endfunction

    function automatic int boosted_power(int x);
        if (x >= 0) return (x * (100 + int'(cfg.boost_percent))) / 100;
        return -(((-x) * (100 - int'(cfg.boost_percent))) / 100);
    endfunction

    function automatic void track_joystick(t_joy_item it);
        logic [jdrc_pkg::MODE_W-1:0] fwd_mode;
        logic [jdrc_pkg::MODE_W-1:0] lm;
        fwd_mode = stick_to_mode(it.fwd);
        lm = stick_to_mode(it.lift);
        right_held = it.right_button;
        left_held = it.left_button;
        if (fwd_mode != drive_mode) begin
            drive_mode = fwd_mode;
            span_cnt = '0;
        end
        if (lm != jdrc_pkg::MODE_STOP) lift_mode = lm;
    endfunction

    function automatic t_power_cmd tick_powers();
        t_power_cmd cmd;
        int tgt;
        int lp;
        int rp;
        cmd = '0;
        if (span_cnt == cfg.update_span) begin
            tgt = 0;
            if (drive_mode == jdrc_pkg::MODE_FWD) tgt = int'(cfg.top_power);
            else if (drive_mode == jdrc_pkg::MODE_BACK) tgt = -int'(cfg.top_power);
            left_lvl = jdrc_pkg::LVL_W'(next_level(int'(left_lvl), tgt));
            right_lvl = jdrc_pkg::LVL_W'(next_level(int'(right_lvl), tgt));
            span_cnt = '0;
        end
        span_cnt = span_cnt + 1'b1;
        lp = int'(left_lvl);
        rp = int'(right_lvl);
        if (!left_held && right_held) lp = boosted_power(lp);
        else if (left_held && !right_held) rp = boosted_power(rp);
        if (lift_mode != lift_sent) begin
            lift_sent = lift_mode;
            if (lift_mode == jdrc_pkg::MODE_FWD) begin
                cmd.lift_valid = 1'b1;
                cmd.lift_move = jdrc_pkg::MOVE_W'(int'(cfg.lift_stroke));
            end else if (lift_mode == jdrc_pkg::MODE_BACK) begin
                cmd.lift_valid = 1'b1;
                cmd.lift_move = jdrc_pkg::MOVE_W'(-int'(cfg.lift_stroke));
            end
        end
        cmd.left_power = jdrc_pkg::OUT_POW_W'(lp);
        cmd.right_power = jdrc_pkg::OUT_POW_W'(rp);
        return cmd;
    endfunction

    function automatic int pick_stick();
        int thr;
        thr = int'(cfg.stick_threshold);
        case ($urandom_range(7))
            0: return 32767;
            1: return -32768;
            2: return thr;
            3: return -thr;
            4: return thr - 1;
            5: return 1 - thr;
            6: return 0;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    function automatic t_joy_item random_item();
        t_joy_item it;
        it.kind = ($urandom_range(3) != 0) ? jdrc_pkg::KIND_TICK : jdrc_pkg::KIND_JOY;
        it.right_button = $urandom_range(1);
        it.left_button = $urandom_range(1);
        it.typed = 1'b0;
        it.want = '0;
        if (it.kind == jdrc_pkg::KIND_JOY) begin
            // mostly keep the drive mode so the span counter can run out
            if ($urandom_range(2) == 0) last_fwd = pick_stick();
            it.fwd = last_fwd;
            it.lift = pick_stick();
        end else begin
            it.fwd = int'($urandom_range(65535)) - 32768;
            it.lift = int'($urandom_range(65535)) - 32768;
        end
        return it;
    endfunction

    task automatic offer(t_joy_item it);
        while ($urandom_range(99) < sender_idle_pct) begin
            joy_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        joy_ch.valid <= 1'b1;
        joy_ch.kind <= it.kind;
        joy_ch.stick_forward <= jdrc_pkg::STICK_W'(it.fwd);
        joy_ch.stick_lift <= jdrc_pkg::STICK_W'(it.lift);
        joy_ch.right_button <= it.right_button;
        joy_ch.left_button <= it.left_button;
        @(posedge i_clk);
        while (!joy_ch.ready) @(posedge i_clk);
        if (it.kind == jdrc_pkg::KIND_TICK) begin
            t_power_cmd cmd;
            cmd = tick_powers();
            pending_cmds.push_back(it.typed ? it.want : cmd);
        end else begin
            track_joystick(it);
        end
    endtask

    task automatic settle();
        joy_ch.valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [jdrc_pkg::CFG_IDX_W-1:0] idx, int value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= jdrc_pkg::CFG_DATA_W'(value);
        @(posedge i_clk);
        case (idx)
            jdrc_pkg::CFG_STICK_THRESHOLD:
                cfg.stick_threshold = jdrc_pkg::THR_W'(value);
            jdrc_pkg::CFG_TOP_POWER:
                cfg.top_power = jdrc_pkg::POW_W'(value);
            jdrc_pkg::CFG_GAIN_TENTHS:
                cfg.gain_tenths = jdrc_pkg::GAIN_W'(value);
            jdrc_pkg::CFG_UPDATE_SPAN:
                cfg.update_span = jdrc_pkg::SPAN_W'(value);
            jdrc_pkg::CFG_BOOST_PERCENT:
                cfg.boost_percent = jdrc_pkg::PCT_W'(value);
            jdrc_pkg::CFG_LIFT_STROKE:
                cfg.lift_stroke = jdrc_pkg::STROKE_W'(value);
            default: ;
        endcase
    endtask

    task automatic configure_phase(int phase);
        case (phase)
            0: begin
                write_reg(jdrc_pkg::CFG_STICK_THRESHOLD, 0);
                write_reg(jdrc_pkg::CFG_TOP_POWER, 127);
                write_reg(jdrc_pkg::CFG_GAIN_TENTHS, 0);
                write_reg(jdrc_pkg::CFG_UPDATE_SPAN, 0);
                write_reg(jdrc_pkg::CFG_BOOST_PERCENT, 0);
                write_reg(jdrc_pkg::CFG_LIFT_STROKE, 0);
            end
            1: begin
                write_reg(jdrc_pkg::CFG_STICK_THRESHOLD, 32767);
                write_reg(jdrc_pkg::CFG_TOP_POWER, 127);
                write_reg(jdrc_pkg::CFG_GAIN_TENTHS, 15);
                write_reg(jdrc_pkg::CFG_UPDATE_SPAN, 1);
                write_reg(jdrc_pkg::CFG_BOOST_PERCENT, 63);
                write_reg(jdrc_pkg::CFG_LIFT_STROKE, 1023);
            end
            2: begin
                write_reg(jdrc_pkg::CFG_STICK_THRESHOLD, 1);
                write_reg(jdrc_pkg::CFG_TOP_POWER, 0);
                write_reg(jdrc_pkg::CFG_GAIN_TENTHS, 10);
                write_reg(jdrc_pkg::CFG_UPDATE_SPAN, 255);
                write_reg(jdrc_pkg::CFG_BOOST_PERCENT, 50);
                write_reg(jdrc_pkg::CFG_LIFT_STROKE, 1);
            end
            default: begin
                write_reg(jdrc_pkg::CFG_STICK_THRESHOLD,
                          $urandom_range(1) ? $urandom_range(32767)
                                            : $urandom_range(20000, 1000));
                write_reg(jdrc_pkg::CFG_TOP_POWER, $urandom_range(127));
                write_reg(jdrc_pkg::CFG_GAIN_TENTHS, $urandom_range(15));
                write_reg(jdrc_pkg::CFG_UPDATE_SPAN, $urandom_range(4));
                write_reg(jdrc_pkg::CFG_BOOST_PERCENT, $urandom_range(63));
                write_reg(jdrc_pkg::CFG_LIFT_STROKE, $urandom_range(1023));
            end
        endcase
        i_cfg_we <= 1'b0;
    endtask

    task automatic check_field(string what, logic signed [15:0] want, logic signed [15:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
        end
    endtask

    // output side: random stalls, plus a long hold-off on request
    initial begin
        cmd_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                cmd_ch.ready <= 1'b0;
                repeat (hold_request) @(posedge i_clk);
                hold_request = 0;
            end
            cmd_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready) begin
            if (pending_cmds.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected transfer, expected none got %0d %0d %0d %0d", $time,
                         cmd_ch.left_power, cmd_ch.right_power, cmd_ch.lift_valid,
                         cmd_ch.lift_move);
            end else begin
                t_power_cmd want;
                want = pending_cmds.pop_front();
                check_field("left_power", want.left_power, cmd_ch.left_power);
                check_field("right_power", want.right_power, cmd_ch.right_power);
                check_field("lift_valid", {15'd0, want.lift_valid}, {15'd0, cmd_ch.lift_valid});
                check_field("lift_move", want.lift_move, cmd_ch.lift_move);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((joy_ch.valid && joy_ch.ready) || (cmd_ch.valid && cmd_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        joy_ch.valid = 1'b0;
        joy_ch.kind = jdrc_pkg::KIND_JOY;
        joy_ch.stick_forward = '0;
        joy_ch.stick_lift = '0;
        joy_ch.right_button = 1'b0;
        joy_ch.left_button = 1'b0;
        cfg.stick_threshold = jdrc_pkg::RST_STICK_THRESHOLD;
        cfg.top_power = jdrc_pkg::RST_TOP_POWER;
        cfg.gain_tenths = jdrc_pkg::RST_GAIN_TENTHS;
        cfg.update_span = jdrc_pkg::RST_UPDATE_SPAN;
        cfg.boost_percent = jdrc_pkg::RST_BOOST_PERCENT;
        cfg.lift_stroke = jdrc_pkg::RST_LIFT_STROKE;
        drive_mode = jdrc_pkg::MODE_STOP;
        span_cnt = '0;
        left_lvl = '0;
        right_lvl = '0;
        right_held = 1'b0;
        left_held = 1'b0;
        lift_mode = jdrc_pkg::MODE_STOP;
        lift_sent = jdrc_pkg::MODE_STOP;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++) offer(directed_rows[r]);
        settle();

        for (int p = 0; p < PHASES; p++) begin
            configure_phase(p);
            sender_idle_pct = (p % 4 == 1) ? 74 : (p % 4 == 3) ? 21 : 0;
            receiver_stall_pct = (p % 4 == 2) ? 74 : (p % 4 == 3) ? 21 : 0;
            // long output hold-off while input keeps offering, fills the queue
            if (p == 4) hold_request = HOLD_CYCLES;
            for (int n = 0; n < PHASE_ITEMS; n++) offer(random_item());
            settle();
        end

        if (mismatch_count == 0 && pending_cmds.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
